@@ hdl/salru_pkg.sv @@
// Shared types and constants for the set-associative LRU cache lookup unit.
`default_nettype none

package salru_pkg;

   // Fixed field widths of the ports
   localparam int ADDR_W      = 16;
   localparam int OFF_W       = 4;
   localparam int IDX_W       = 3;
   localparam int WAYS_W      = 3;
   localparam int CSR_DATA_W  = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int WAY_OUT_W   = 2;

   // Tag shift is offset plus index bit counts; raw set index is masked to at most 2^IDX_W-1 bits
   localparam int SHIFT_W   = 5;
   localparam int SET_RAW_W = (1 << IDX_W) - 1;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   // Reset values of the configuration registers
   localparam logic [OFF_W-1:0]  OFF_RESET  = 4'd2;
   localparam logic [IDX_W-1:0]  IDX_RESET  = 3'd2;
   localparam logic [WAYS_W-1:0] WAYS_RESET = 3'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch set/tag, start row read
      logic commit;    // write back the row, load the result register
   } salru_cmd_type;

endpackage

`default_nettype wire

@@ hdl/salru_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module salru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]        wr_data,
   input  logic                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/salru_ctrl.sv @@
// Controller state machine: sequences row read, lookup/write-back and result hand-off.
`default_nettype none

module salru_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output salru_pkg::salru_cmd_type cmd
);
   import salru_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      // drop the result once its transfer completes
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // hold while an untaken result still sits in the output register
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/salru_dp.sv @@
// Datapath: configuration, address split, tag/LRU row store, way selection and result register.
`default_nettype none

module salru_dp #(
   parameter int MAX_SETS  = 16,
   parameter int MAX_WAYS  = 4,
   parameter int ADDR_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  salru_pkg::salru_cmd_type              cmd,
   input  logic                                  csr_write_enable,
   input  logic [salru_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [salru_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic [salru_pkg::ADDR_W-1:0]          req_address,
   output logic                                  rsp_hit,
   output logic [salru_pkg::WAY_OUT_W-1:0]       rsp_way
);
   import salru_pkg::*;

   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W    = WAY_W;
   localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
   localparam int TAG_W     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int ROW_W     = MAX_WAYS * (1 + TAG_W + RANK_W);
   localparam int SET_TAB_N = 1 << SET_RAW_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                             ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   // Configuration registers
   logic [OFF_W-1:0]  offset_bits_ff;
   logic [IDX_W-1:0]  index_bits_ff;
   logic [WAYS_W-1:0] ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFF_RESET;
         index_bits_ff  <= IDX_RESET;
         ways_ff        <= WAYS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OFFSET_BITS: offset_bits_ff <= csr_write_data[OFF_W-1:0];
            CSR_INDEX_BITS:  index_bits_ff  <= csr_write_data[IDX_W-1:0];
            CSR_WAYS_IN_USE: ways_ff        <= csr_write_data[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   // Address split
   logic [ADDR_W-1:0]    addr_eff;
   logic [ADDR_W-1:0]    addr_shifted;
   logic [ADDR_W-1:0]    tag_full;
   logic [SHIFT_W-1:0]   tag_shift;
   logic [SET_RAW_W-1:0] idx_mask;
   logic [SET_RAW_W-1:0] set_raw;
   logic [SET_W-1:0]     req_set;
   logic [TAG_W-1:0]     req_tag;
   logic [SET_W-1:0]     set_tab [SET_TAB_N];

   // Aliased set indexes wrap onto the store
   for (genvar g = 0; g < SET_TAB_N; g++) begin : g_set_tab
      assign set_tab[g] = SET_W'(g % MAX_SETS);
   end

   assign addr_eff     = req_address & ADDR_MASK;
   assign addr_shifted = addr_eff >> offset_bits_ff;
   assign idx_mask     = SET_RAW_W'(((SET_RAW_W + 1)'(1) << index_bits_ff) - (SET_RAW_W + 1)'(1));
   assign set_raw      = SET_RAW_W'(addr_shifted) & idx_mask;
   assign req_set      = set_tab[set_raw];
   assign tag_shift    = SHIFT_W'(offset_bits_ff) + SHIFT_W'(index_bits_ff);
   assign tag_full     = addr_eff >> tag_shift;
   assign req_tag      = TAG_W'(tag_full);

   // Per-set written flags: a set never written reads as the reset row
   logic [MAX_SETS-1:0] row_written_ff;
   logic [SET_W-1:0]    set_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic                row_fresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_written_ff <= '0;
      end else if (cmd.commit) begin
         row_written_ff[set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         set_ff       <= req_set;
         tag_ff       <= req_tag;
         row_fresh_ff <= ~row_written_ff[req_set];
      end
   end

   // Row store: valid bits, tags and age ranks of one set per entry
   logic [ROW_W-1:0] row_rd;
   logic [ROW_W-1:0] row_new;

   salru_ram #(
      .WIDTH(ROW_W),
      .DEPTH(MAX_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (set_ff),
      .wr_data (row_new),
      .rd_en   (cmd.capture),
      .rd_addr (req_set),
      .rd_data (row_rd)
   );

   logic [MAX_WAYS-1:0]             cur_valid;
   logic [MAX_WAYS-1:0][TAG_W-1:0]  cur_tag;
   logic [MAX_WAYS-1:0][RANK_W-1:0] cur_rank;

   always_comb begin
      if (row_fresh_ff) begin
         cur_valid = '0;
         cur_tag   = '0;
         for (int w = 0; w < MAX_WAYS; w++) begin
            cur_rank[w] = RANK_W'(w);
         end
      end else begin
         {cur_valid, cur_tag, cur_rank} = row_rd;
      end
   end

   // Way selection
   logic [WCNT_W-1:0]   ways_eff;
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] empty;
   logic [MAX_WAYS-1:0] oldest;

   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ff);
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (WCNT_W'(w) < ways_eff);
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         match[w]  = in_use[w] & cur_valid[w] & (cur_tag[w] == tag_ff);
         empty[w]  = in_use[w] & ~cur_valid[w];
         // ranks are distinct, so exactly one way in use is oldest
         oldest[w] = in_use[w];
         for (int v = 0; v < MAX_WAYS; v++) begin
            if (in_use[v] && (cur_rank[v] > cur_rank[w])) begin
               oldest[w] = 1'b0;
            end
         end
      end
   end

   logic                            lookup_hit;
   logic [MAX_WAYS-1:0]             pick;
   logic [WAY_W-1:0]                chosen;
   logic [RANK_W-1:0]               chosen_rank;
   logic [MAX_WAYS-1:0]             new_valid;
   logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;
   logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;

   always_comb begin
      lookup_hit = |match;
      if (lookup_hit) begin
         pick = match;
      end else if (|empty) begin
         pick = empty;
      end else begin
         pick = oldest;
      end
      // lowest flagged way wins
      chosen = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (pick[w]) begin
            chosen = WAY_W'(w);
         end
      end
      chosen_rank = cur_rank[chosen];
      // chosen way becomes youngest, ways younger than it age by one
      for (int k = 0; k < MAX_WAYS; k++) begin
         if (WAY_W'(k) == chosen) begin
            new_rank[k] = '0;
         end else if (cur_rank[k] < chosen_rank) begin
            new_rank[k] = RANK_W'(cur_rank[k] + 1'b1);
         end else begin
            new_rank[k] = cur_rank[k];
         end
      end
      new_valid = cur_valid;
      new_tag   = cur_tag;
      if (!lookup_hit) begin
         new_valid[chosen] = 1'b1;
         new_tag[chosen]   = tag_ff;
      end
   end

   assign row_new = {new_valid, new_tag, new_rank};

   // Result register
   logic                 rsp_hit_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff <= lookup_hit;
         rsp_way_ff <= WAY_OUT_W'(chosen);
      end
   end

   assign rsp_hit = rsp_hit_ff;
   assign rsp_way = rsp_way_ff;

endmodule

`default_nettype wire

@@ hdl/set_associative_lru_cache_lookup_unit.sv @@
// Top level of the set-associative cache tag lookup with true LRU replacement.
//
// Usage:
//   - Request channel (req_valid/req_ready/req_address): one byte address per transfer.
//   - Response channel (rsp_valid/rsp_ready/rsp_hit/rsp_way): one result per request, in
//     order; rsp_hit flags a tag match, rsp_way is the way that hit, was filled or replaced.
//   - Configuration (csr_write_enable/csr_index/csr_write_data): offset bit count, index bit
//     count and ways in use; write only while no request is in flight.
//   - A transferred request moves the controller to its lookup state, which loads the result
//     register once the output register is free or its waiting result transfers.
//   - One request in flight at a time, set by the row store: the set's row is read first,
//     then all ways are compared in parallel and the row is written back.
//   - A new request is taken while the previous result still waits in the output register;
//     if the receiver stalls, the next lookup holds before write-back until that result
//     transfers, and req_ready stays low meanwhile.
//   - Reset: configuration returns to 2/2/4 and every set reads as empty with ranks equal
//     to way numbers at once through per-set written flags; no clearing pass is needed.
`default_nettype none

module set_associative_lru_cache_lookup_unit #(
   parameter int MAX_SETS  = 16,
   parameter int MAX_WAYS  = 4,
   parameter int ADDR_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [salru_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [salru_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [salru_pkg::ADDR_W-1:0]      req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [salru_pkg::WAY_OUT_W-1:0]   rsp_way
);
   import salru_pkg::*;

   salru_cmd_type cmd;

   // Controller: sequences capture and commit, owns the handshakes
   salru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: address split, row store, way pick, LRU update, result register
   salru_dp #(
      .MAX_SETS  (MAX_SETS),
      .MAX_WAYS  (MAX_WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_address      (req_address),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way)
   );

   // One lookup at a time: a transfer in closes the request side for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a lookup is in flight");

   // Never overwrite a result that has not transferred
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before transfer");

   // Capture and commit never coincide
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");

   // A reported way lies inside the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_way) < MAX_WAYS))
      else $error("reported way beyond the store");

endmodule

`default_nettype wire

@@ tb/sv/set_associative_lru_cache_lookup_unit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the cache lookup unit: tag store predictor plus in-order result comparison.
module set_associative_lru_cache_lookup_unit_checker #(
   parameter int SET_COUNT = 16,
   parameter int WAY_COUNT = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [salru_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [salru_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [salru_pkg::ADDR_W-1:0]      req_address,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_hit,
   input  logic [salru_pkg::WAY_OUT_W-1:0]   rsp_way,
   output int                                mismatch_count,
   output int                                outstanding
);

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic                              hit;
      logic [salru_pkg::WAY_OUT_W-1:0]   way;
      logic [salru_pkg::ADDR_W-1:0]      address;
   } lookup_result_type;

   lookup_result_type expected_lookups [$];

   logic                             line_valid [SET_COUNT][WAY_COUNT];
   logic [15:0]                      line_tag   [SET_COUNT][WAY_COUNT];
   logic [1:0]                       age_rank   [SET_COUNT][WAY_COUNT];
   logic [salru_pkg::OFF_W-1:0]      cfg_offset;
   logic [salru_pkg::IDX_W-1:0]      cfg_index;
   logic [salru_pkg::WAYS_W-1:0]     cfg_ways;

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic clear_store();
      cfg_offset = salru_pkg::OFF_RESET;
      cfg_index  = salru_pkg::IDX_RESET;
      cfg_ways   = salru_pkg::WAYS_RESET;
      for (int s = 0; s < SET_COUNT; s++) begin
         for (int w = 0; w < WAY_COUNT; w++) begin
            line_valid[s][w] = 1'b0;
            line_tag[s][w]   = '0;
            age_rank[s][w]   = 2'(w);
         end
      end
   endtask

   // Look the address up, update the store and the ranks, and give back the result.
   function automatic lookup_result_type lookup_and_update(
      input logic [salru_pkg::ADDR_W-1:0] address);
      lookup_result_type res;
      int             ways_eff;
      int             set_no;
      int             chosen;
      logic [31:0]    tag_val;
      logic [1:0]     old_rank;
      bit             found;
      bit             hit;
      ways_eff = int'(cfg_ways);
      if (ways_eff < 1) ways_eff = 1;
      if (ways_eff > WAY_COUNT) ways_eff = WAY_COUNT;
      // index masks to its bit count, then wraps onto the sets that exist
      set_no = int'(((32'(address) >> cfg_offset) & ((32'd1 << cfg_index) - 32'd1))
                    % 32'(SET_COUNT));
      // a shift past the address width leaves a zero tag
      tag_val = 32'(address) >> (int'(cfg_offset) + int'(cfg_index));
      hit    = 1'b0;
      found  = 1'b0;
      chosen = 0;
      for (int w = 0; w < ways_eff; w++) begin
         if (!found && line_valid[set_no][w] && line_tag[set_no][w] == tag_val[15:0]) begin
            hit    = 1'b1;
            found  = 1'b1;
            chosen = w;
         end
      end
      for (int w = 0; w < ways_eff; w++) begin
         if (!found && !line_valid[set_no][w]) begin
            found  = 1'b1;
            chosen = w;
         end
      end
      if (!found) begin
         for (int w = 1; w < ways_eff; w++)
            if (age_rank[set_no][w] > age_rank[set_no][chosen]) chosen = w;
      end
      if (!hit) begin
         line_valid[set_no][chosen] = 1'b1;
         line_tag[set_no][chosen]   = tag_val[15:0];
      end
      old_rank = age_rank[set_no][chosen];
      for (int k = 0; k < WAY_COUNT; k++)
         if (age_rank[set_no][k] < old_rank) age_rank[set_no][k] = age_rank[set_no][k] + 2'd1;
      age_rank[set_no][chosen] = 2'd0;
      res.hit     = hit;
      res.way     = salru_pkg::WAY_OUT_W'(chosen);
      res.address = address;
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      lookup_result_type head;
      if (reset) begin
         clear_store();
         expected_lookups.delete();
         outstanding <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               salru_pkg::CSR_OFFSET_BITS: cfg_offset = csr_write_data[salru_pkg::OFF_W-1:0];
               salru_pkg::CSR_INDEX_BITS:  cfg_index  = csr_write_data[salru_pkg::IDX_W-1:0];
               salru_pkg::CSR_WAYS_IN_USE: cfg_ways   = csr_write_data[salru_pkg::WAYS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch($sformatf("result with no lookup pending: hit=%b way=%0d",
                                         rsp_hit, rsp_way));
            end else begin
               head = expected_lookups.pop_front();
               if (rsp_hit !== head.hit)
                  report_mismatch($sformatf("address %h: hit %b, predicted %b",
                                            head.address, rsp_hit, head.hit));
               if (rsp_way !== head.way)
                  report_mismatch($sformatf("address %h: way %0d, predicted %0d",
                                            head.address, rsp_way, head.way));
            end
         end
         if (req_valid && req_ready) expected_lookups.push_back(lookup_and_update(req_address));
         outstanding <= expected_lookups.size();
      end
   end

endmodule

@@ tb/sv/set_associative_lru_cache_lookup_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top: address and configuration stimulus for the cache lookup unit, and the verdict.
module set_associative_lru_cache_lookup_unit_test;
   import salru_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 4;
   localparam int STALL_LIMIT     = 1000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int PHASE_COUNT     = 9;
   localparam int PHASE_ITEMS     = 97;
   localparam int POOL_SIZE       = 12;
   localparam int DRAIN_CYCLES    = 10;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_ready;
   logic [ADDR_W-1:0]      req_address;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_hit;
   logic [WAY_OUT_W-1:0]   rsp_way;

   int                     mismatch_count;
   int                     outstanding;
   int                     stall_cycles;

   // Idling on both sides follows allow_idle; hold_off_pending asks the
   // receiver for one long stall so the block backs up into its input.
   bit                     allow_idle;
   bit                     hold_off_pending;

   // Settings of the random phases: offset bits, index bits, ways in use.
   // They sweep the extremes: offset 0 and 15, index 0 and 7, ways 0, 1, 4 and 7,
   // and one setting where offset plus index runs past the address width.
   int phase_offset [PHASE_COUNT] = '{2, 0, 4, 15, 3, 8, 1, 12, 0};
   int phase_index  [PHASE_COUNT] = '{2, 4, 1, 0, 7, 5, 3, 6, 2};
   int phase_ways   [PHASE_COUNT] = '{4, 4, 3, 2, 4, 1, 0, 7, 4};

   // Recently used addresses; revisiting them is what makes hits and LRU churn.
   logic [ADDR_W-1:0]      address_pool [POOL_SIZE];
   logic [OFF_W-1:0]       cur_offset;
   logic [IDX_W-1:0]       cur_index;

   always #HALF_PERIOD clock = ~clock;

   set_associative_lru_cache_lookup_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way)
   );

   set_associative_lru_cache_lookup_unit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   // Offer one address and hold it until the transfer happens. An idle burst,
   // when drawn, drops valid first; otherwise valid stays high from the
   // previous transfer, so it never gets two assignments in one step.
   task automatic transfer_address(input logic [ADDR_W-1:0] address);
      int gap;
      if (allow_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= address;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every lookup has returned its result.
   // The first edge is always waited out, so the last transfer is counted.
   task automatic drain_lookups();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write all three registers back to back while the block is idle.
   task automatic write_config(input logic [OFF_W-1:0] offset_bits,
                               input logic [IDX_W-1:0] index_bits,
                               input logic [WAYS_W-1:0] ways);
      drain_lookups();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_OFFSET_BITS;
      csr_write_data   <= CSR_DATA_W'(offset_bits);
      @(posedge clock);
      csr_index        <= CSR_INDEX_BITS;
      csr_write_data   <= CSR_DATA_W'(index_bits);
      @(posedge clock);
      csr_index        <= CSR_WAYS_IN_USE;
      csr_write_data   <= CSR_DATA_W'(ways);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_offset = offset_bits;
      cur_index  = index_bits;
   endtask

   // Pick the next address: half revisit a recent line (another byte of it),
   // some build a small tag over a random set to force conflicts and
   // replacement, and the rest are fully random noise.
   function automatic logic [ADDR_W-1:0] next_address();
      logic [31:0] built;
      logic [31:0] offset_mask;
      logic [31:0] index_mask;
      int          slot;
      int          pick;
      offset_mask = (32'd1 << cur_offset) - 32'd1;
      index_mask  = (32'd1 << cur_index) - 32'd1;
      pick = $urandom_range(0, 9);
      slot = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 5) begin
         built = 32'(address_pool[slot]) ^ ($urandom & offset_mask);
      end else if (pick < 8) begin
         built = (32'($urandom_range(0, 7)) << (int'(cur_offset) + int'(cur_index)))
               | (($urandom & index_mask) << cur_offset)
               | ($urandom & offset_mask);
      end else begin
         built = $urandom;
      end
      address_pool[slot] = built[ADDR_W-1:0];
      return built[ADDR_W-1:0];
   endfunction

   // Receiver: random stall bursts, or one long hold-off when asked for.
   // The hold-off is counted here, while the sender keeps offering addresses.
   initial begin : drive_result_ready
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (allow_idle && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("set_associative_lru_cache_lookup_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin : drive_stimulus
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_OFFSET_BITS;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_address      = '0;
      allow_idle       = 1'b1;
      hold_off_pending = 1'b0;
      cur_offset       = OFF_RESET;
      cur_index        = IDX_RESET;
      for (int i = 0; i < POOL_SIZE; i++) address_pool[i] = ADDR_W'($urandom);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: a zero tag on an empty line must miss, then hit; fill
      // set 0 with four tags, replace the oldest, hit, and replace again.
      transfer_address(16'h0000);
      transfer_address(16'h0000);
      transfer_address(16'hFFFF);
      transfer_address(16'h0010);
      transfer_address(16'h0020);
      transfer_address(16'h0030);
      transfer_address(16'h0040);
      transfer_address(16'h0010);
      transfer_address(16'h0050);
      transfer_address(16'h5555);
      transfer_address(16'hAAAA);

      // Largest offset and index: the index field is wider than the store but only one
      // address bit reaches it, tag is zero, and too many ways clamp to the maximum.
      write_config(4'd15, 3'd7, 3'd7);
      transfer_address(16'h0000);
      transfer_address(16'h8000);
      transfer_address(16'h7FFF);
      transfer_address(16'hFFFF);

      // No offset or index bits, zero ways acting as direct mapped.
      write_config(4'd0, 3'd0, 3'd0);
      transfer_address(16'h1234);
      transfer_address(16'h1234);
      transfer_address(16'hFFFF);

      // Build the same tag in two ways by shrinking and growing the ways in
      // use, then check that the lower way wins. The store is not cleared
      // by any of these writes.
      write_config(4'd0, 3'd0, 3'd1);
      transfer_address(16'h00A5);
      write_config(4'd0, 3'd0, 3'd2);
      transfer_address(16'h00B6);
      write_config(4'd0, 3'd0, 3'd1);
      transfer_address(16'h00B6);
      write_config(4'd0, 3'd0, 3'd2);
      transfer_address(16'h00B6);
      transfer_address(16'h00A5);

      // Random phases; one runs without idling, the last one too, and the
      // second one carries the long receiver hold-off.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_config(OFF_W'(phase_offset[p]), IDX_W'(phase_index[p]),
                      WAYS_W'(phase_ways[p]));
         allow_idle = (p != 3) && (p != PHASE_COUNT - 1);
         if (p == 1) hold_off_pending = 1'b1;
         repeat (PHASE_ITEMS) transfer_address(next_address());
      end

      drain_lookups();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("set_associative_lru_cache_lookup_unit: match");
      end else begin
         $display("set_associative_lru_cache_lookup_unit: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/salru_pkg.sv
hdl/salru_ram.sv
hdl/salru_ctrl.sv
hdl/salru_dp.sv
hdl/set_associative_lru_cache_lookup_unit.sv
tb/sv/set_associative_lru_cache_lookup_unit_checker.sv
tb/sv/set_associative_lru_cache_lookup_unit_test.sv
